// ===== rtl/core/dbp_pkg.sv =====
`default_nettype none
package dbp_pkg;

  localparam int WORD_BITS  = 32;
  localparam int SEG_BITS   = 28;
  localparam int SEG_LEN_W  = 5;
  localparam int BCNT_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int ENTRY_W    = 19;

  localparam logic [CFG_IDX_W-1:0] REG_TREE_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LIT     = 1'd1;

  typedef enum logic [1:0] {OP_TOKEN, OP_LOAD, OP_RAW, OP_FLUSH} op_t;
  typedef enum logic {PH_A, PH_B} phase_t;

  typedef struct packed {
    logic       tree_select;
    logic [8:0] num_lit_codes;
  } cfg_t;

  // one queued request: up to two bit segments, or a flush
  typedef struct packed {
    logic                 flush;
    logic [SEG_BITS-1:0]  val_a;
    logic [SEG_LEN_W-1:0] len_a;
    logic [SEG_BITS-1:0]  val_b;
    logic [SEG_LEN_W-1:0] len_b;
  } step_t;

  localparam logic [8:0] LENGTH_BASE [29] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
  localparam logic [3:0] LEN_XB [29] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd0};
  localparam logic [15:0] DIST_BASE [30] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
    16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
    16'd8193, 16'd12289, 16'd16385, 16'd24577};
  localparam logic [3:0] DIST_XB [30] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

  function automatic logic [4:0] len_code(input logic [8:0] len);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < 29; i++) begin
      if (len >= LENGTH_BASE[i]) c = 5'(i);
    end
    return c;
  endfunction

  function automatic logic [4:0] dist_code(input logic [15:0] dst);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < 30; i++) begin
      if (dst >= DIST_BASE[i]) c = 5'(i);
    end
    return c;
  endfunction

  function automatic logic [14:0] ones15(input logic [3:0] n);
    logic [14:0] m;
    m = '0;
    for (int i = 0; i < 15; i++) begin
      m[i] = (4'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8-i];
    end
    return r;
  endfunction

  // fixed literal/length code: {length, bit-reversed code}
  function automatic logic [12:0] fixed_lit(input logic [8:0] s);
    logic [8:0] v;
    logic [3:0] n;
    if (s < 9'd144) begin
      v = 9'h030 + s;
      n = 4'd8;
    end else if (s < 9'd256) begin
      v = 9'h190 + (s - 9'd144);
      n = 4'd9;
    end else if (s < 9'd280) begin
      v = s - 9'd256;
      n = 4'd7;
    end else begin
      v = 9'h0C0 + (s - 9'd280);
      n = 4'd8;
    end
    // left-align then reverse so the code lands in the low bits
    return {n, rev9(v << (4'd9 - n))};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dbp_if.sv =====
`default_nettype none
interface dbp_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        is_match;
  logic [8:0]  literal;
  logic [8:0]  match_len;
  logic [15:0] distance;
  logic [8:0]  entry_index;
  logic [14:0] entry_code;
  logic [3:0]  entry_length;
  logic [14:0] raw_value;
  logic [3:0]  raw_count;
  modport source(output valid, op, is_match, literal, match_len, distance,
                 entry_index, entry_code, entry_length, raw_value, raw_count,
                 input ready);
  modport sink(input valid, op, is_match, literal, match_len, distance,
               entry_index, entry_code, entry_length, raw_value, raw_count,
               output ready);
endinterface

interface dbp_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  out_bytes;
  logic        last_of_run;
  modport source(output valid, out_word, out_bytes, last_of_run, input ready);
  modport sink(input valid, out_word, out_bytes, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dbp_front.sv =====
`default_nettype none
module dbp_front
  import dbp_pkg::*;
#(
  parameter int TABLE_DEPTH = 320
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  dbp_tok_if.sink    tokens,
  output logic       push_valid,
  input  wire logic  push_ready,
  output step_t      push_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [9:0] DEPTH_L = 10'(TABLE_DEPTH);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  // stage 1 registers
  logic        s1_valid;
  op_t         s1_op;
  logic        s1_match;
  logic [8:0]  s1_sym;
  logic [4:0]  s1_dc;
  logic [4:0]  s1_xval1;
  logic [3:0]  s1_xlen1;
  logic [12:0] s1_xval2;
  logic [3:0]  s1_xlen2;
  logic        s1_dist_ok;
  logic [14:0] s1_raw_val;
  logic [3:0]  s1_raw_cnt;
  logic [ENTRY_W-1:0] rd_lit;
  logic [ENTRY_W-1:0] rd_dist;

  logic        accept;
  logic        s1_push;
  op_t         in_op;
  logic [8:0]  lit_sym;
  logic [8:0]  len_c;
  logic [15:0] dst_c;
  logic [4:0]  lc;
  logic [4:0]  dc;
  logic [8:0]  sym;
  logic [9:0]  dist_idx;

  assign in_op   = op_t'(tokens.op);
  assign s1_push = s1_valid && (s1_op != OP_LOAD);
  assign tokens.ready = !s1_push || push_ready;
  assign accept  = tokens.valid && tokens.ready;

  // symbol classification
  always_comb begin
    lit_sym = (tokens.literal > 9'd256) ? 9'd256 : tokens.literal;
    len_c = tokens.match_len;
    if (len_c < 9'd3) len_c = 9'd3;
    if (len_c > 9'd258) len_c = 9'd258;
    dst_c = tokens.distance;
    if (dst_c == 16'd0) dst_c = 16'd1;
    if (dst_c > 16'd32768) dst_c = 16'd32768;
    lc = len_code(len_c);
    dc = dist_code(dst_c);
    sym = tokens.is_match ? (9'd257 + 9'(lc)) : lit_sym;
    dist_idx = {1'b0, cfg.num_lit_codes} + 10'(dc);
  end

  // code table: load write and two registered reads
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_op == OP_LOAD && {1'b0, tokens.entry_index} < DEPTH_L) begin
        mem[tokens.entry_index[AW-1:0]] <= {tokens.entry_length, tokens.entry_code};
      end
      rd_lit  <= mem[sym[AW-1:0]];
      rd_dist <= mem[dist_idx[AW-1:0]];
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (!s1_push || push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= in_op;
      s1_match   <= tokens.is_match;
      s1_sym     <= sym;
      s1_dc      <= dc;
      s1_xval1   <= tokens.is_match ? 5'(len_c - LENGTH_BASE[lc]) : 5'd0;
      s1_xlen1   <= tokens.is_match ? LEN_XB[lc] : 4'd0;
      s1_xval2   <= 13'(dst_c - DIST_BASE[dc]);
      s1_xlen2   <= DIST_XB[dc];
      s1_dist_ok <= dist_idx < DEPTH_L;
      s1_raw_val <= tokens.raw_value;
      s1_raw_cnt <= tokens.raw_count;
    end
  end

  // code selection and segment building
  logic [14:0] code1, code2;
  logic [3:0]  clen1, clen2;
  logic [12:0] fx;

  always_comb begin
    fx = fixed_lit(s1_sym);
    if (cfg.tree_select) begin
      clen1 = rd_lit[18:15];
      code1 = rd_lit[14:0] & ones15(clen1);
      clen2 = s1_dist_ok ? rd_dist[18:15] : 4'd0;
      code2 = rd_dist[14:0] & ones15(clen2);
    end else begin
      clen1 = fx[12:9];
      code1 = {6'd0, fx[8:0]};
      clen2 = 4'd5;
      code2 = {10'd0, s1_dc[0], s1_dc[1], s1_dc[2], s1_dc[3], s1_dc[4]};
    end
    push_data = '0;
    case (s1_op)
      OP_TOKEN: begin
        push_data.val_a = {13'd0, code1} | (SEG_BITS'(s1_xval1) << clen1);
        push_data.len_a = 5'(clen1) + 5'(s1_xlen1);
        if (s1_match) begin
          push_data.val_b = {13'd0, code2} | (SEG_BITS'(s1_xval2) << clen2);
          push_data.len_b = 5'(clen2) + 5'(s1_xlen2);
        end
      end
      OP_RAW: begin
        push_data.val_a = {13'd0, s1_raw_val & ones15(s1_raw_cnt)};
        push_data.len_a = 5'(s1_raw_cnt);
      end
      OP_FLUSH: push_data.flush = 1'b1;
      default: push_data = '0;
    endcase
  end

  assign push_valid = s1_push;

endmodule
`default_nettype wire

// ===== rtl/core/dbp_queue.sv =====
`default_nettype none
module dbp_queue
  import dbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire step_t push_data,
  output logic       pop_valid,
  input  wire logic  pop,
  output step_t      pop_data
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  step_t          entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           do_push, do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dbp_back.sv =====
`default_nettype none
module dbp_back
  import dbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire step_t q_data,
  output logic       q_pop,
  dbp_res_if.source  results
);

  phase_t phase, phase_next;
  logic [WORD_BITS-1:0] buffer, buffer_next;
  logic [BCNT_W-1:0]    bcnt, bcnt_next;

  logic                 step_go;
  logic [SEG_BITS-1:0]  val;
  logic [SEG_LEN_W-1:0] len;
  logic [63:0]          merged;
  logic [BCNT_W-1:0]    sum;
  logic                 full;
  logic [BCNT_W-1:0]    cnt_after;
  logic                 b_emits;
  logic                 emit;
  logic                 emit_last;
  logic [2:0]           emit_bytes;

  assign step_go = q_valid && (!results.valid || results.ready);

  // append one segment to the bit buffer
  always_comb begin
    val = (phase == PH_A) ? q_data.val_a : q_data.val_b;
    len = (phase == PH_A) ? q_data.len_a : q_data.len_b;
    merged = {32'd0, buffer} | ({36'd0, val} << bcnt);
    sum = bcnt + BCNT_W'(len);
    full = (sum >= BCNT_W'(WORD_BITS));
    cnt_after = full ? (sum - BCNT_W'(WORD_BITS)) : sum;
    b_emits = (cnt_after + BCNT_W'(q_data.len_b)) >= BCNT_W'(WORD_BITS);
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (step_go) begin
      case (phase)
        PH_A: if (!q_data.flush && q_data.len_b != '0) phase_next = PH_B;
        PH_B: phase_next = PH_A;
        default: phase_next = PH_A;
      endcase
    end
  end

  // step outputs
  always_comb begin
    q_pop = 1'b0;
    emit = 1'b0;
    emit_last = 1'b1;
    emit_bytes = 3'd4;
    buffer_next = buffer;
    bcnt_next = bcnt;
    if (step_go) begin
      case (phase)
        PH_A: begin
          if (q_data.flush) begin
            q_pop = 1'b1;
            emit = (bcnt != '0);
            emit_bytes = 3'((bcnt + 6'd7) >> 3);
            buffer_next = '0;
            bcnt_next = '0;
          end else begin
            q_pop = (q_data.len_b == '0);
            emit = full;
            emit_last = !b_emits;
            buffer_next = full ? merged[63:32] : merged[31:0];
            bcnt_next = cnt_after;
          end
        end
        PH_B: begin
          q_pop = 1'b1;
          emit = full;
          buffer_next = full ? merged[63:32] : merged[31:0];
          bcnt_next = cnt_after;
        end
        default: q_pop = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_A;
      buffer <= '0;
      bcnt   <= '0;
    end else begin
      phase  <= phase_next;
      buffer <= buffer_next;
      bcnt   <= bcnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.out_word    <= merged[31:0];
      results.out_bytes   <= emit_bytes;
      results.last_of_run <= emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_below_word: assert property (@(posedge clk) disable iff (rst)
    bcnt < BCNT_W'(WORD_BITS)) else $error("bit count reached a full word");
  a_phase_b_has_entry: assert property (@(posedge clk) disable iff (rst)
    phase == PH_B |-> q_valid) else $error("second phase without a queued request");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    step_go && phase == PH_A && q_data.flush |=> bcnt == '0)
    else $error("flush left bits in buffer");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/deflate_token_bit_packer_unit.sv =====
`default_nettype none
// DEFLATE token bit packer.
// Requests arrive on the tokens channel (valid/ready): a literal or match
// token, a code table load, raw header bits, or a flush to a byte boundary.
// Packed 32-bit words leave on the results channel, byte 0 in bits 7..0,
// with the count of valid bytes and a flag on the last word of a request.
// Configuration (tree select, literal code count) is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// A request enters a stage with the registered table read, then a
// four-entry queue; the packer appends its bit segments to the bit buffer
// one at a time and registers each finished word in the output register;
// loads never reach the packer. The front takes one request per cycle
// while the queue has room; the packer handles a match token with distance
// bits in phase A (length part) and then phase B (distance part), and any
// other request in phase A only, each phase waiting on a stalled receiver.
// Reset clears the bit buffer, count and configuration; the code table is
// undefined until loaded. A stalled receiver holds the output register;
// the queue keeps accepting until it fills, then ready drops.
module deflate_token_bit_packer_unit
  import dbp_pkg::*;
#(
  parameter int TABLE_DEPTH = 320
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  dbp_tok_if.sink                    tokens,
  dbp_res_if.source                  results
);

  cfg_t  cfg;
  logic  push_valid, push_ready;
  step_t push_data;
  logic  q_valid, q_pop;
  step_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tree_select   <= 1'b0;
      cfg.num_lit_codes <= 9'd288;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TREE_SELECT: cfg.tree_select   <= cfg_data[0];
        REG_NUM_LIT:     cfg.num_lit_codes <= cfg_data;
        default:         cfg.tree_select   <= cfg.tree_select;
      endcase
    end
  end

  dbp_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst, .cfg, .tokens,
    .push_valid, .push_ready, .push_data
  );

  dbp_queue u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_data,
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
  );

  dbp_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .results
  );

endmodule
`default_nettype wire

// ===== dv/tb_deflate_token_bit_packer_unit.sv =====
`default_nettype none
module tb_deflate_token_bit_packer_unit;
  import dbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAB_DEPTH   = 320;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    op_t        op;
    bit         is_match;
    bit [8:0]   literal;
    bit [8:0]   match_len;
    bit [15:0]  distance;
    bit [8:0]   entry_index;
    bit [14:0]  entry_code;
    bit [3:0]   entry_length;
    bit [14:0]  raw_value;
    bit [3:0]   raw_count;
  } tok_req_t;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  nbytes;
    bit        last;
  } packed_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbp_tok_if tokens ();
  dbp_res_if results ();

  deflate_token_bit_packer_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .tokens(tokens), .results(results)
  );

  // RFC 1951 length and distance tables
  localparam int LENGTH_BASE_TAB[29] = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19,
                                         23, 27, 31, 35, 43, 51, 59, 67, 83, 99, 115,
                                         131, 163, 195, 227, 258};
  localparam int LENGTH_XBITS_TAB[29] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
                                          3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0};
  localparam int DIST_BASE_TAB[30] = '{1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97,
                                       129, 193, 257, 385, 513, 769, 1025, 1537, 2049,
                                       3073, 4097, 6145, 8193, 12289, 16385, 24577};
  localparam int DIST_XBITS_TAB[30] = '{0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
                                        7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13};

  // packer state as predicted
  bit          use_dynamic;
  bit [8:0]    lit_code_count;
  bit [63:0]   pack_buf;
  int unsigned pack_cnt;
  bit [14:0]   dyn_code [TAB_DEPTH];
  bit [3:0]    dyn_len  [TAB_DEPTH];

  packed_word_t expected_words[$];
  packed_word_t new_words[$];

  int errors;
  int words_seen;
  int reqs_sent;
  int cycles;
  bit src_idle;
  bit sink_idle;
  int sink_hold;

  function automatic bit [14:0] reverse_bits(bit [14:0] v, int n);
    bit [14:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[n-1-i] = v[i];
    return r;
  endfunction

  // append n bits, lsb first; emit a word whenever 32 bits are complete
  function automatic void append_bits(bit [14:0] v, int n);
    bit [63:0] val;
    int room;
    packed_word_t w;
    val = 64'(v) & ((64'd1 << n) - 1);
    room = 32 - pack_cnt;
    if (n == 0) return;
    if (n < room) begin
      pack_buf |= val << pack_cnt;
      pack_cnt += n;
      return;
    end
    pack_buf |= (val & ((64'd1 << room) - 1)) << pack_cnt;
    w.word = pack_buf[31:0];
    w.nbytes = 3'd4;
    w.last = 1'b0;
    new_words = {new_words, w};
    pack_buf = (room < n) ? (val >> room) : 64'd0;
    pack_cnt = n - room;
  endfunction

  function automatic void append_symbol(int s, bit is_dist);
    int idx;
    if (use_dynamic) begin
      idx = is_dist ? int'(lit_code_count) + s : s;
      if (idx < TAB_DEPTH) append_bits(dyn_code[idx], int'(dyn_len[idx]));
      return;
    end
    if (is_dist) append_bits(reverse_bits(15'(s), 5), 5);
    else if (s < 144) append_bits(reverse_bits(15'(48 + s), 8), 8);
    else if (s < 256) append_bits(reverse_bits(15'(400 + s - 144), 9), 9);
    else if (s < 280) append_bits(reverse_bits(15'(s - 256), 7), 7);
    else append_bits(reverse_bits(15'(192 + s - 280), 8), 8);
  endfunction

  function automatic void predict_request(tok_req_t r);
    int len, dst, lc, dc;
    packed_word_t w;
    new_words.delete();
    case (r.op)
      OP_TOKEN: begin
        if (!r.is_match) begin
          append_symbol(r.literal > 256 ? 256 : int'(r.literal), 1'b0);
        end else begin
          len = r.match_len;
          dst = r.distance;
          if (len < 3) len = 3;
          if (len > 258) len = 258;
          if (dst < 1) dst = 1;
          if (dst > 32768) dst = 32768;
          lc = 0;
          dc = 0;
          for (int i = 0; i < 29; i++) if (LENGTH_BASE_TAB[i] <= len) lc = i;
          for (int i = 0; i < 30; i++) if (DIST_BASE_TAB[i] <= dst) dc = i;
          append_symbol(257 + lc, 1'b0);
          append_bits(15'(len - LENGTH_BASE_TAB[lc]), LENGTH_XBITS_TAB[lc]);
          append_symbol(dc, 1'b1);
          append_bits(15'(dst - DIST_BASE_TAB[dc]), DIST_XBITS_TAB[dc]);
        end
      end
      OP_LOAD: begin
        if (r.entry_index < TAB_DEPTH) begin
          dyn_code[r.entry_index] = r.entry_code;
          dyn_len[r.entry_index] = r.entry_length;
        end
      end
      OP_RAW: append_bits(r.raw_value, int'(r.raw_count));
      default: begin
        if (pack_cnt > 0) begin
          w.word = pack_buf[31:0];
          w.nbytes = 3'((pack_cnt + 7) / 8);
          w.last = 1'b0;
          new_words = {new_words, w};
          pack_buf = '0;
          pack_cnt = 0;
        end
      end
    endcase
    if (new_words.size() > 2) new_words = new_words[0:1];
    foreach (new_words[k]) begin
      w = new_words[k];
      w.last = (k == new_words.size() - 1);
      expected_words = {expected_words, w};
    end
  endfunction

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("tb_deflate_token_bit_packer_unit failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      if (sink_hold == 0) results.ready <= 1'b1;
    end else if (results.valid && results.ready && sink_idle) begin
      sink_hold = $urandom_range(0, 19);
      if (sink_hold > 0) results.ready <= 1'b0;
    end
  end

  // compare each word with the oldest expectation
  always @(posedge clk) begin
    packed_word_t e;
    if (!rst && results.valid && results.ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, actual %h bytes %0d last %0b", $time,
                 results.out_word, results.out_bytes, results.last_of_run);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (results.out_word !== e.word) begin
          $display("%0t: out_word expected %h actual %h", $time, e.word, results.out_word);
          errors++;
        end
        if (results.out_bytes !== e.nbytes) begin
          $display("%0t: out_bytes expected %0d actual %0d", $time, e.nbytes,
                   results.out_bytes);
          errors++;
        end
        if (results.last_of_run !== e.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, e.last,
                   results.last_of_run);
          errors++;
        end
      end
    end
  end

  // one request, with a random gap in front
  task automatic send_req(tok_req_t r);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      tokens.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tokens.valid <= 1'b1;
    tokens.op <= r.op;
    tokens.is_match <= r.is_match;
    tokens.literal <= r.literal;
    tokens.match_len <= r.match_len;
    tokens.distance <= r.distance;
    tokens.entry_index <= r.entry_index;
    tokens.entry_code <= r.entry_code;
    tokens.entry_length <= r.entry_length;
    tokens.raw_value <= r.raw_value;
    tokens.raw_count <= r.raw_count;
    do @(posedge clk); while (!tokens.ready);
    predict_request(r);
    reqs_sent++;
  endtask

  task automatic wait_idle();
    tokens.valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TREE_SELECT) use_dynamic = val[0];
    else lit_code_count = val;
  endtask

  function automatic tok_req_t blank_req(op_t op);
    tok_req_t r;
    r = '{op: op, default: '0};
    r.op = op;
    return r;
  endfunction

  function automatic tok_req_t lit_req(int lit);
    tok_req_t r;
    r = blank_req(OP_TOKEN);
    r.literal = 9'(lit);
    return r;
  endfunction

  function automatic tok_req_t match_req(int len, int dst);
    tok_req_t r;
    r = blank_req(OP_TOKEN);
    r.is_match = 1'b1;
    r.match_len = 9'(len);
    r.distance = 16'(dst);
    return r;
  endfunction

  function automatic tok_req_t raw_req(int val, int cnt);
    tok_req_t r;
    r = blank_req(OP_RAW);
    r.raw_value = 15'(val);
    r.raw_count = 4'(cnt);
    return r;
  endfunction

  function automatic tok_req_t load_req(int idx);
    tok_req_t r;
    r = blank_req(OP_LOAD);
    r.entry_index = 9'(idx);
    r.entry_code = 15'($urandom_range(0, 32767));
    r.entry_length = ($urandom_range(0, 6) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    return r;
  endfunction

  // mostly in-range tokens, some out-of-range fields, raw bits, flushes, loads
  function automatic tok_req_t random_req(bit allow_load);
    int pick;
    tok_req_t r;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r = lit_req($urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 256));
    end else if (pick < 85) begin
      r = match_req($urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(3, 258),
                    $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(1, 32768));
    end else if (pick < 93) begin
      r = raw_req($urandom_range(0, 32767), $urandom_range(0, 15));
    end else if (pick < 97 || !allow_load) begin
      r = blank_req(OP_FLUSH);
    end else begin
      r = load_req($urandom_range(0, 8) == 0 ? $urandom_range(320, 511) : $urandom_range(0, 319));
    end
    // unused fields of a flush carry noise too
    if (r.op == OP_FLUSH) begin
      r.is_match = 1'($urandom);
      r.literal = 9'($urandom);
      r.raw_value = 15'($urandom);
      r.raw_count = 4'($urandom);
    end
    return r;
  endfunction

  task automatic run_random(int n, bit allow_load);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        src_idle = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
      end
      send_req(random_req(allow_load));
    end
    wait_idle();
  endtask

  // fixed codes: field extremes and every special case
  task automatic test_fixed_directed();
    int lits[7] = '{0, 143, 144, 255, 256, 257, 511};
    write_reg(REG_TREE_SELECT, 9'd0);
    write_reg(REG_NUM_LIT, 9'd288);
    send_req(blank_req(OP_FLUSH));
    foreach (lits[i]) send_req(lit_req(lits[i]));
    send_req(match_req(3, 1));
    send_req(match_req(258, 32768));
    send_req(match_req(0, 0));
    send_req(match_req(511, 65535));
    send_req(match_req(11, 5));
    send_req(match_req(227, 24577));
    send_req(raw_req(0, 0));
    send_req(raw_req(32767, 15));
    send_req(raw_req(21845, 13));
    send_req(load_req(319));
    send_req(load_req(511));
    send_req(blank_req(OP_FLUSH));
    send_req(blank_req(OP_FLUSH));
    send_req(raw_req(5, 3));
    send_req(blank_req(OP_FLUSH));
    wait_idle();
  endtask

  task automatic test_fixed_random();
    run_random(300, 1'b0);
  endtask

  // dynamic codes: set the literal code count, then stream random requests with loads
  task automatic test_dynamic(int lit_count, int n);
    write_reg(REG_TREE_SELECT, 9'd1);
    write_reg(REG_NUM_LIT, 9'(lit_count));
    run_random(n, 1'b1);
  endtask

  task automatic test_table_load();
    src_idle = 1'b0;
    for (int i = 0; i < TAB_DEPTH; i++) send_req(load_req(i));
    send_req(load_req(320));
    send_req(load_req(511));
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tokens.valid = 1'b0;
    tokens.op = OP_TOKEN;
    tokens.is_match = 1'b0;
    tokens.literal = '0;
    tokens.match_len = '0;
    tokens.distance = '0;
    tokens.entry_index = '0;
    tokens.entry_code = '0;
    tokens.entry_length = '0;
    tokens.raw_value = '0;
    tokens.raw_count = '0;
    results.ready = 1'b1;
    use_dynamic = 1'b0;
    lit_code_count = 9'd288;
    pack_buf = '0;
    pack_cnt = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fixed_directed();
    test_fixed_random();
    test_table_load();
    test_dynamic(257, 300);
    test_dynamic(288, 250);
    test_dynamic(300, 150);
    test_dynamic(511, 100);
    write_reg(REG_TREE_SELECT, 9'd0);
    run_random(100, 1'b1);

    $display("Covered fixed and dynamic codes, code counts 257..511, raw bits and flushes:");
    $display("%0d requests sent, %0d packed words checked", reqs_sent, words_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_deflate_token_bit_packer_unit passed");
    end else begin
      $display("tb_deflate_token_bit_packer_unit failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
